// ===== hw/rtl/mwcma_pkg.sv =====
// ----------------------------------------------------------------------------
// mwcma_pkg: shared types for the multi-width centered moving average
// Stage load strobes passed from the top level to the window units, and
// the fixed output format.
// ----------------------------------------------------------------------------
package mwcma_pkg;

	// unsigned Q.8 result field
	localparam int OUT_WIDTH = 24;
	localparam int FRAC_BITS = 8;
	localparam int IN_WIDTH  = 16;

	// load strobes of the shared pipeline, one per stage after the taps
	typedef struct packed {
		logic ld_sum;  // tap data folded into the running sums
		logic ld_mul;  // sum times reciprocal
		logic ld_chk;  // estimate times window length
		logic ld_out;  // corrected quotient into the output register
	} adv_t;

endpackage

// ===== hw/rtl/mwcma_ram.sv =====
// ----------------------------------------------------------------------------
// mwcma_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mwcma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/mwcma_win.sv =====
// ----------------------------------------------------------------------------
// mwcma_win: one averaging window
// Keeps the running window sum and divides sum*256 by 2*HALF+1 through a
// reciprocal multiply, a back-multiply and a one-step correction.
// ----------------------------------------------------------------------------
module mwcma_win #(
	parameter int HALF        = 10,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mwcma_pkg::adv_t                   adv,
	input  logic [COUNT_WIDTH-1:0]            add_val,
	input  logic [COUNT_WIDTH-1:0]            sub_val,
	output logic [mwcma_pkg::OUT_WIDTH-1:0]   avg
);

	localparam int OW   = mwcma_pkg::OUT_WIDTH;
	localparam int LEN  = 2 * HALF + 1;
	localparam int LW   = $clog2(LEN + 1);
	localparam int SW   = COUNT_WIDTH + $clog2(LEN + 1);
	localparam int K    = SW + mwcma_pkg::FRAC_BITS;
	localparam int RW   = K;
	localparam int MW   = K - (LW - 1);
	localparam int PW   = SW + MW;
	localparam longint unsigned M_FULL = (64'd1 << K) / LEN;
	localparam logic [MW-1:0] M_V   = M_FULL[MW-1:0];
	localparam logic [LW-1:0] LEN_V = LW'(LEN);
	localparam logic [RW-1:0] LEN_R = RW'(LEN);

	logic [SW-1:0]    sum_q;
	logic [PW-1:0]    prod_s3;
	logic [SW-1:0]    sum_s3;
	logic [MW-1:0]    qe_s4;
	logic [RW-1:0]    qlen_s4;
	logic [RW-1:0]    x_s4;
	logic [MW-1:0]    qe;
	logic [MW+LW-1:0] qlen_full;
	logic [RW-1:0]    rem;
	logic [MW:0]      q_fix;
	logic [OW-1:0]    avg_q;

	// (sum*256)*M >> K, expressed on the unshifted sum: drop the low SW bits
	assign qe        = prod_s3[PW-1:SW];
	assign qlen_full = qe * LEN_V;
	assign rem       = x_s4 - qlen_s4;
	// estimate is never high and at most one low
	assign q_fix     = {1'b0, qe_s4} + {{MW{1'b0}}, (rem >= LEN_R)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv.ld_sum) begin
			sum_q <= sum_q + SW'(add_val) - SW'(sub_val);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_mul) begin
			prod_s3 <= sum_q * M_V;
			sum_s3  <= sum_q;
		end
		if (adv.ld_chk) begin
			qe_s4   <= qe;
			qlen_s4 <= qlen_full[RW-1:0];
			x_s4    <= {sum_s3, {mwcma_pkg::FRAC_BITS{1'b0}}};
		end
		if (adv.ld_out) begin
			avg_q <= OW'(q_fix);
		end
	end

	assign avg = avg_q;

endmodule

// ===== hw/rtl/multi_width_centered_moving_average_unit.sv =====
// A beat accepted passes the tap read, sum, multiply, check and output registers before m_tvalid.
// Throughput: one beat per cycle while m_tready does not stall; each of up to five history RAMs
// serves one fixed tap with one read per cycle, newest count forwarded from the input.
// The first LONG_HALF beats give no result. Reset is asynchronous and ready
// at once: a fill counter masks unwritten history slots, so no clearing pass.
// ----------------------------------------------------------------------------
// multi_width_centered_moving_average_unit: three centered box averages
// Ring history of counts, running sums over half-widths SHORT/MID/LONG and
// floor(sum*256/(2w+1)) per window, centre lagging the input by LONG_HALF.
// ----------------------------------------------------------------------------
module multi_width_centered_moving_average_unit #(
	parameter int SHORT_HALF    = 10,
	parameter int MID_HALF      = 100,
	parameter int LONG_HALF     = 1000,
	parameter int HISTORY_DEPTH = 2048,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [23:0] avg_short, [47:24] avg_mid, [71:48] avg_long
);

	localparam int CW  = COUNT_WIDTH;
	localparam int D   = HISTORY_DEPTH;
	localparam int AW  = $clog2(D);
	localparam int FW  = $clog2(D + 1);
	localparam int WW  = $clog2(LONG_HALF + 1);
	localparam int OW  = mwcma_pkg::OUT_WIDTH;
	localparam int NT  = 6;
	// taps: short add/sub, mid add/sub, long add/sub (back distance from newest)
	localparam int TAP_BACK [NT] = '{
		(((LONG_HALF - SHORT_HALF) % D) + D) % D,
		(((LONG_HALF + SHORT_HALF + 1) % D) + D) % D,
		(((LONG_HALF - MID_HALF) % D) + D) % D,
		(((LONG_HALF + MID_HALF + 1) % D) + D) % D,
		0,
		(((2 * LONG_HALF + 1) % D) + D) % D
	};

	logic [AW-1:0] wp_q;
	logic [FW-1:0] fill_q;
	logic [WW-1:0] warm_q;
	logic          accept;
	logic          emit_s0;
	logic [CW-1:0] cnt_in;

	logic          v1_q, v2_q, v3_q, v4_q, vo_q;
	logic          emit_s1, emit_s2;
	logic [CW-1:0] count_s1;
	logic [NT-1:0] tap_ok_s1;
	logic [NT-1:0] tap_ok;
	logic          rdy1, rdy2, rdy3, rdy4, rdy_o;
	mwcma_pkg::adv_t adv;

	logic [CW-1:0] tap_raw [NT];
	logic [CW-1:0] tap_val [NT];
	logic [OW-1:0] avg_short, avg_mid, avg_long;

	assign cnt_in  = CW'(s_tdata);
	assign emit_s0 = (warm_q == WW'(LONG_HALF));

	// stage ready chain, each stage moves when it is empty or its successor moves
	assign rdy_o    = !vo_q || m_tready;
	assign rdy4     = !v4_q || rdy_o;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;

	assign adv.ld_sum = v1_q && rdy2;
	assign adv.ld_mul = v2_q && emit_s2 && rdy3;
	assign adv.ld_chk = v3_q && rdy4;
	assign adv.ld_out = v4_q && rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			warm_q <= '0;
		end else if (accept) begin
			wp_q <= (wp_q == AW'(D - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q != FW'(D)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (!emit_s0) begin
				warm_q <= warm_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= s_tvalid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			// warm-up beats end here after updating the sums
			if (rdy3) begin
				v3_q <= v2_q && emit_s2;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
			if (rdy_o) begin
				vo_q <= v4_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1  <= cnt_in;
			tap_ok_s1 <= tap_ok;
			emit_s1   <= emit_s0;
		end
		if (adv.ld_sum) begin
			emit_s2 <= emit_s1;
		end
	end

	// one history copy per tap that reaches back into the past
	for (genvar i = 0; i < NT; i++) begin : g_tap
		localparam logic [AW:0] BACK = (AW + 1)'(TAP_BACK[i]);
		// fill_q+1 slots written counting this beat, older ones still read as zero
		assign tap_ok[i]  = (FW'(TAP_BACK[i]) <= fill_q);
		assign tap_val[i] = tap_ok_s1[i] ? tap_raw[i] : '0;

		if (TAP_BACK[i] == 0) begin : g_fwd
			assign tap_raw[i] = count_s1;
		end else begin : g_mem
			logic [AW:0]   wp_ext;
			logic [AW:0]   diff;
			logic [AW:0]   wrapped;
			logic [AW-1:0] raddr;

			assign wp_ext  = {1'b0, wp_q};
			assign diff    = wp_ext - BACK;
			assign wrapped = wp_ext + (AW + 1)'(D) - BACK;
			assign raddr   = (wp_ext >= BACK) ? diff[AW-1:0] : wrapped[AW-1:0];

			mwcma_ram #(
				.WIDTH (CW),
				.DEPTH (D)
			) u_hist (
				.clk   (clk),
				.we    (accept),
				.waddr (wp_q),
				.wdata (cnt_in),
				.re    (accept),
				.raddr (raddr),
				.rdata (tap_raw[i])
			);
		end
	end

	mwcma_win #(
		.HALF        (SHORT_HALF),
		.COUNT_WIDTH (CW)
	) u_win_short (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.add_val (tap_val[0]),
		.sub_val (tap_val[1]),
		.avg     (avg_short)
	);

	mwcma_win #(
		.HALF        (MID_HALF),
		.COUNT_WIDTH (CW)
	) u_win_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.add_val (tap_val[2]),
		.sub_val (tap_val[3]),
		.avg     (avg_mid)
	);

	mwcma_win #(
		.HALF        (LONG_HALF),
		.COUNT_WIDTH (CW)
	) u_win_long (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.add_val (tap_val[4]),
		.sub_val (tap_val[5]),
		.avg     (avg_long)
	);

	assign m_tvalid = vo_q;
	assign m_tdata  = {avg_long, avg_mid, avg_short};

endmodule
